// ===== rtl/nec_ir_frame_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// NEC IR decoder assertion macros
// Shared concurrent assertion shorthands, sampled on the rising clock edge and
// off while the asynchronous reset is applied.
// ----------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// same-cycle implication
`define NIRFD_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NIRFD_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nirfd_pkg.sv =====
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Shared widths, the remote code table and the key lookup helpers.
// ----------------------------------------------------------------------------
package nirfd_pkg;

	localparam int CODE_W  = 32;
	localparam int CNT_W   = 6;
	localparam int TIME_W  = 16;
	localparam int TPM_W   = 13;
	localparam int DIGIT_W = 4;
	localparam int KEY_NUM = 20;

	// input kind carried in s_tuser
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_READ = 1'b1;

	// two remote variants per digit, digit = entry / 2
	localparam logic [CODE_W-1:0] KEY_CODES [KEY_NUM] = '{
		32'h00FF6897, 32'h00FD0CF3, 32'h00FF30CF, 32'h00FD10EF, 32'h00FF18E7,
		32'h00FD11EE, 32'h00FF7A85, 32'h00FD12ED, 32'h00FF10EF, 32'h00FD14EB,
		32'h00FF38C7, 32'h00FD15EA, 32'h00FF5AA5, 32'h00FD16E9, 32'h00FF42BD,
		32'h00FD18E7, 32'h00FF4AB5, 32'h00FD19E6, 32'h00FF52AD, 32'h00FD1AE5
	};

	typedef struct packed {
		logic                hit;
		logic [DIGIT_W-1:0]  digit;
	} key_t;

	function automatic logic [7:0] flip8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7-i] = b[i];
		end
		return r;
	endfunction

	// first table entry that matches wins
	function automatic key_t key_lookup(input logic [CODE_W-1:0] code);
		key_t k;
		k.hit   = 1'b0;
		k.digit = '0;
		for (int i = KEY_NUM - 1; i >= 0; i--) begin
			if (KEY_CODES[i] == code) begin
				k.hit   = 1'b1;
				k.digit = DIGIT_W'(i >> 1);
			end
		end
		return k;
	endfunction

endpackage

// ===== rtl/nirfd_keymap.sv =====
// ----------------------------------------------------------------------------
// NEC IR key map
// Translates a received 32-bit code to a digit, trying the code with its low
// two bytes bit-reversed first and the raw code second.
// ----------------------------------------------------------------------------
module nirfd_keymap import nirfd_pkg::*; (
	input  logic [CODE_W-1:0] code,
	output key_t              key
);

	logic [CODE_W-1:0] alt_code;
	key_t              raw_key;
	key_t              alt_key;

	assign alt_code = {code[31:16], flip8(code[15:8]), flip8(code[7:0])};
	assign raw_key  = key_lookup(code);
	assign alt_key  = key_lookup(alt_code);

	always_comb begin
		priority if (alt_key.hit) begin
			key = alt_key;
		end else if (raw_key.hit) begin
			key = raw_key;
		end else begin
			key = '0;
		end
	end

endmodule

// ===== rtl/nec_ir_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder
// Pulse-distance frame decoder driven by falling-edge capture timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one beat per event: s_tuser = 0 is a capture edge with its
//   timestamp in s_tdata, s_tuser = 1 is a key read request.
//   m_* returns exactly one beat per input beat, in order:
//   m_tdata = {key_ready, key_digit, frame_done, pad} from bit 0 up.
//   cfg_* writes ticks_per_ms (timer ticks per ms); write it only while idle.
//   The result of a beat is registered and shown on m_* right after the
//   edge that accepts it. Throughput is one beat per cycle, bounded by
//   the single output register: s_tready is high whenever that register is
//   empty or is being drained in the same cycle.
//   When m_tready stays low, one result is held and s_tready drops until it
//   is taken; nothing is lost.
//   Reset clears the timestamp, bit counter, code register and ready flag,
//   and sets ticks_per_ms to 100.
// ----------------------------------------------------------------------------
`include "nec_ir_frame_decoder_assert.svh"

module nec_ir_frame_decoder import nirfd_pkg::*; #(
	parameter int FRAME_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// config: ticks_per_ms[12:0]
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TPM_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // [15:0] capture_time
	input  logic              s_tuser,   // [0] op
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata    // [0] key_ready, [4:1] key_digit, [5] frame_done
);

	localparam logic [CNT_W-1:0] FB_CNT = CNT_W'(FRAME_BITS);

	logic [TPM_W+3:0]    hi_thr_q;   // 10 * ticks_per_ms
	logic [TPM_W:0]      lo_thr_q;   // 2 * ticks_per_ms
	logic [TIME_W-1:0]   last_time_q;
	logic [CNT_W-1:0]    edge_cnt_q;
	logic [CODE_W-1:0]   code_q;
	logic                ready_q;
	logic                m_valid_q;
	logic [7:0]          m_data_q;

	logic                in_acc;
	logic                is_edge;
	logic [TIME_W:0]     diff;
	logic                start;
	logic                in_frame;
	logic                complete;
	logic [CNT_W-1:0]    bit_pos;
	logic [CNT_W-1:0]    cnt_base;
	logic [CODE_W-1:0]   code_nxt;
	key_t                key;
	logic                res_ready;
	logic [DIGIT_W-1:0]  res_digit;
	logic                res_done;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_valid_q || m_tready;
	assign in_acc    = s_tvalid && s_tready;
	assign is_edge   = (s_tuser == OP_EDGE);

	// signed interval; bit TIME_W is the sign
	assign diff     = {1'b0, s_tdata} - {1'b0, last_time_q};
	assign start    = diff[TIME_W] || ((TPM_W+4)'(diff[TIME_W-1:0]) > hi_thr_q);
	assign in_frame = (edge_cnt_q != '0) && (edge_cnt_q <= FB_CNT);
	assign bit_pos  = FB_CNT - edge_cnt_q;
	assign complete = !start && (edge_cnt_q >= FB_CNT);
	assign cnt_base = (start || complete) ? '0 : edge_cnt_q;

	logic bit_one;
	assign bit_one = ({1'b0, diff[TIME_W-1:0]} >= (TIME_W+1)'(lo_thr_q));

	always_comb begin
		code_nxt = code_q;
		priority if (start) begin
			code_nxt = '0;
		end else if (in_frame && bit_one) begin
			code_nxt[bit_pos[4:0]] = 1'b1;
		end
	end

	nirfd_keymap u_keymap (
		.code (code_q),
		.key  (key)
	);

	always_comb begin
		res_ready = 1'b0;
		res_digit = '0;
		res_done  = 1'b0;
		if (is_edge) begin
			res_done = complete;
		end else if (ready_q) begin
			res_ready = 1'b1;
			res_digit = key.digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_thr_q <= (TPM_W+4)'(1000);
			lo_thr_q <= (TPM_W+1)'(200);
		end else if (cfg_valid && cfg_ready) begin
			hi_thr_q <= ({4'b0, cfg_data} << 3) + ({4'b0, cfg_data} << 1);
			lo_thr_q <= {cfg_data, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			edge_cnt_q  <= '0;
			code_q      <= '0;
			ready_q     <= 1'b0;
		end else if (in_acc) begin
			if (is_edge) begin
				last_time_q <= s_tdata;
				edge_cnt_q  <= cnt_base + CNT_W'(1);
				code_q      <= code_nxt;
				if (complete) begin
					ready_q <= 1'b1;
				end
			end else begin
				ready_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			m_data_q <= {2'b00, res_done, res_digit, res_ready};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	`NIRFD_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, edge_cnt_q <= FB_CNT,
		"edge counter beyond frame length")
	`NIRFD_ASSERT_NXT(a_frame_sets_ready, clk, arst_n, in_acc && is_edge && complete,
		ready_q && m_tvalid && m_tdata[5], "completed frame not flagged")
	`NIRFD_ASSERT_NXT(a_read_clears, clk, arst_n, in_acc && !is_edge,
		!ready_q && m_tvalid && !m_tdata[5], "read did not consume ready flag")
	`NIRFD_ASSERT_IMP(a_digit_needs_ready, clk, arst_n, m_tvalid && !m_tdata[0],
		m_tdata[4:1] == 4'd0, "digit reported without a pending key")

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// NEC IR frame decoder testbench
// Drives capture-edge and key-read beats through the stream ports and
// predicts every result beat with a cycle-free decoder model kept in step
// with the config. A short table of corner beats runs first. Random frames
// follow: well formed, broken, or followed by repeat edges, mixed with
// noise beats. Each phase runs with its own ticks_per_ms setting; the
// idle pattern on each side is shared by the phases in pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import nirfd_pkg::*;

	localparam int FRAME_BITS = 32;

	typedef struct packed {
		logic                ready;
		logic [DIGIT_W-1:0]  digit;
		logic                done;
	} key_result_t;

	typedef struct packed {
		logic         op;
		logic [15:0]  stamp;
		logic         typed;
		key_result_t  want;
	} stim_row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [TPM_W-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;    // [15:0] capture_time
	logic              s_tuser = 1'b0;  // [0] op
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;         // [0] key_ready, [4:1] key_digit, [5] frame_done

	// decoder model state
	logic [TIME_W-1:0] ir_last_time = '0;
	logic [CNT_W-1:0]  ir_count = '0;
	logic [CODE_W-1:0] ir_code = '0;
	logic              ir_pending = 1'b0;
	logic [TPM_W-1:0]  ir_tpm = 13'd100;

	key_result_t expected_keys [$];
	int mismatch_count = 0;
	int beat_count = 0;
	int frame_no = 0;
	int stim_time = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;

	nec_ir_frame_decoder #(
		.FRAME_BITS(FRAME_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [CODE_W-1:0] flip_low_bytes(input logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] r;
		r = code;
		for (int i = 0; i < 8; i++) begin
			r[i]     = code[7-i];
			r[8 + i] = code[15-i];
		end
		return r;
	endfunction

	// digit of the first matching table entry, -1 if none
	function automatic int key_slot(input logic [CODE_W-1:0] code);
		int slot;
		slot = -1;
		for (int i = 0; i < KEY_NUM; i++) begin
			if (slot < 0 && KEY_CODES[i] == code)
				slot = i / 2;
		end
		return slot;
	endfunction

	function automatic key_result_t predict_decode(input logic op, input logic [15:0] stamp);
		key_result_t r;
		int gap, hi, lo, raw, alt;
		r = '0;
		if (op == OP_EDGE) begin
			gap = int'(stamp) - int'(ir_last_time);
			hi = 10 * int'(ir_tpm);
			lo = 2 * int'(ir_tpm);
			if (gap > hi || gap < 0) begin
				ir_count = '0;
				ir_code = '0;
			end else if (ir_count >= 1 && ir_count <= FRAME_BITS) begin
				if (gap >= lo)
					ir_code[FRAME_BITS - int'(ir_count)] = 1'b1;
			end
			if (ir_count >= FRAME_BITS) begin
				ir_pending = 1'b1;
				r.done = 1'b1;
				ir_count = '0;
			end
			ir_last_time = stamp;
			ir_count = ir_count + CNT_W'(1);
		end else if (ir_pending) begin
			raw = key_slot(ir_code);
			alt = key_slot(flip_low_bytes(ir_code));
			// the bit-reversed form wins over the raw one
			if (alt >= 0)
				r.digit = DIGIT_W'(alt);
			else if (raw >= 0)
				r.digit = DIGIT_W'(raw);
			r.ready = 1'b1;
			ir_pending = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %0s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	always @(posedge clk) begin : result_check
		key_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_keys.size() == 0) begin
				report_mismatch($sformatf("result beat %h with nothing pending", m_tdata));
			end else begin
				want = expected_keys.pop_front();
				if (m_tdata[0] !== want.ready)
					report_mismatch($sformatf("key_ready %b, want %b", m_tdata[0], want.ready));
				if (m_tdata[4:1] !== want.digit)
					report_mismatch($sformatf("key_digit %0d, want %0d", m_tdata[4:1], want.digit));
				if (m_tdata[5] !== want.done)
					report_mismatch($sformatf("frame_done %b, want %b", m_tdata[5], want.done));
			end
		end
	end

	task automatic send_beat(input logic op, input logic [15:0] stamp,
			input logic typed = 1'b0, input key_result_t want = '0);
		key_result_t got;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= stamp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		got = predict_decode(op, stamp);
		expected_keys.push_back(typed ? want : got);
		if (op == OP_EDGE)
			stim_time = int'(stamp);
		beat_count++;
	endtask

	// hold off the sender until every pending result has drained
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_keys.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_tpm(input logic [TPM_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		ir_tpm = value;
	endtask

	function automatic int bit_gap(input logic one);
		int v;
		v = int'(ir_tpm);
		if (v == 0)
			return 0;
		case ($urandom_range(0, 9))
			0: return one ? 2 * v : 2 * v - 1;
			1: return one ? 10 * v : 0;
			default: return one ? int'($urandom_range(2 * v, 3 * v))
				: int'($urandom_range(v / 2, 2 * v - 1));
		endcase
	endfunction

	// start gap, then up to 32 bit edges; timestamps that run past the
	// counter wrap and break the frame, which is wanted now and then
	task automatic send_frame();
		logic [CODE_W-1:0] code;
		int nbits, start, want_t, reads;
		if ($urandom_range(0, 1)) begin
			code = KEY_CODES[$urandom_range(0, KEY_NUM - 1)];
			if ($urandom_range(0, 1))
				code = flip_low_bytes(code);
		end else begin
			code = $urandom;
		end
		nbits = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 31)) : FRAME_BITS;

		want_t = stim_time + 10 * int'(ir_tpm) + 1 + int'($urandom_range(0, 200));
		if (stim_time > 32768 || want_t > 65535)
			start = (stim_time > 0) ? int'($urandom_range(0, stim_time - 1)) : 65535;
		else
			start = want_t;
		send_beat(OP_EDGE, 16'(start));

		for (int k = FRAME_BITS - 1; k >= FRAME_BITS - nbits; k--)
			send_beat(OP_EDGE, 16'(stim_time + bit_gap(code[k])));

		// repeat edges keep shifting into the same code
		if (nbits == FRAME_BITS && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 4))
				send_beat(OP_EDGE, 16'(stim_time + bit_gap($urandom_range(0, 1))));
		end

		reads = $urandom_range(0, 3);
		if (reads == 3)
			reads = 2;
		repeat (reads)
			send_beat(OP_READ, 16'($urandom));
	endtask

	initial begin
		stim_row_t directed_rows [$];
		int tpm_plan [6];
		int pick;

		tpm_plan = '{1, 6000, 0, 2955, 37, 100};

		// reset value ticks_per_ms = 100: start above 1000, bit 1 from 200
		directed_rows.push_back('{OP_READ, 16'd0,     1'b1, '{1'b0, 4'd0, 1'b0}});
		directed_rows.push_back('{OP_EDGE, 16'd0,     1'b1, '{1'b0, 4'd0, 1'b0}});
		directed_rows.push_back('{OP_EDGE, 16'd65535, 1'b1, '{1'b0, 4'd0, 1'b0}});
		directed_rows.push_back('{OP_EDGE, 16'd65535, 1'b0, '0});
		directed_rows.push_back('{OP_EDGE, 16'd0,     1'b1, '{1'b0, 4'd0, 1'b0}});
		directed_rows.push_back('{OP_EDGE, 16'd1000,  1'b0, '0});
		directed_rows.push_back('{OP_EDGE, 16'd1199,  1'b0, '0});
		directed_rows.push_back('{OP_EDGE, 16'd1399,  1'b0, '0});
		directed_rows.push_back('{OP_EDGE, 16'd2400,  1'b0, '0});
		directed_rows.push_back('{OP_EDGE, 16'd2600,  1'b0, '0});
		directed_rows.push_back('{OP_EDGE, 16'd32767, 1'b0, '0});
		directed_rows.push_back('{OP_EDGE, 16'd32768, 1'b0, '0});
		directed_rows.push_back('{OP_EDGE, 16'hAAAA,  1'b0, '0});
		directed_rows.push_back('{OP_EDGE, 16'h5555,  1'b0, '0});
		directed_rows.push_back('{OP_READ, 16'hFFFF,  1'b1, '{1'b0, 4'd0, 1'b0}});
		directed_rows.push_back('{OP_READ, 16'h0000,  1'b1, '{1'b0, 4'd0, 1'b0}});

		src_idle_pct = 8;
		sink_idle_pct = 69;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].op, directed_rows[i].stamp,
				directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < 6; p++) begin
			write_tpm(TPM_W'(tpm_plan[p]));
			case (p / 2)
				0: begin
					src_idle_pct = 8;
					sink_idle_pct = 69;
				end
				1: begin
					src_idle_pct = 69;
					sink_idle_pct = 8;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			while (beat_count < directed_rows.size() + 70 * (p + 1)) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					send_frame();
					frame_no++;
					if (frame_no % 7 == 3)
						settle();
				end else if (pick < 85) begin
					send_beat(OP_EDGE, 16'($urandom));
				end else begin
					send_beat(OP_READ, 16'($urandom));
				end
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
